// ----- rtl/stb_pkg.sv -----
// ----------------------------------------------------------------------------
// stb_pkg
// Shared types and constants for the software timer bank: request modes,
// the stored timer entry, and the request/completion bundles that pass
// between the top level and the entry sequencer.
// ----------------------------------------------------------------------------
package stb_pkg;

   localparam int MODE_W    = 3;
   localparam int ID_W      = 8;
   localparam int PERIOD_W  = 16;
   localparam int MASK_W    = 8;
   localparam int RUN_W     = 31;
   localparam int FREE_W    = 32;

   // Run counter returns to zero when an increment lands on this value
   localparam logic [RUN_W-1:0] RUN_WRAP = 31'h7FFF_FFFF;

   typedef enum logic [MODE_W-1:0] {
      MODE_TICK        = 3'd0,
      MODE_START_ONE   = 3'd1,
      MODE_START_AUTO  = 3'd2,
      MODE_STOP        = 3'd3,
      MODE_CHECK       = 3'd4,
      MODE_CLEAR_FREE  = 3'd5
   } mode_type;

   // One timer as held in memory
   typedef struct packed {
      logic [PERIOD_W-1:0] remaining;
      logic [PERIOD_W-1:0] reload_value;
      logic                expired_flag;
      logic                auto_reload;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // Work handed to the sequencer
   typedef struct packed {
      mode_type            mode;
      logic [ID_W-1:0]     timer_id;
      logic [PERIOD_W-1:0] period;
   } cmd_type;

   // Completion reported back by the sequencer
   typedef struct packed {
      logic              valid;
      logic              expired;
      logic [MASK_W-1:0] fired_mask;
   } done_type;

endpackage

// ----- rtl/stb_ram.sv -----
// ----------------------------------------------------------------------------
// stb_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered.
// ----------------------------------------------------------------------------
module stb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                                clock,
   input  logic                                wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                    wr_data,
   input  logic                                rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                    rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/stb_seq.sv -----
// ----------------------------------------------------------------------------
// stb_seq
// Entry sequencer: reads a timer entry, modifies it and writes it back.
// A tick sweeps every entry, reading the next one while writing the current
// one; start, stop and check touch a single entry. Per-entry valid bits make
// a never-written entry read as all zero.
// ----------------------------------------------------------------------------
module stb_seq #(
   parameter int NUM_TIMERS = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              go,
   input  stb_pkg::cmd_type  cmd,
   output logic              busy,
   output stb_pkg::done_type done
);

   localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TIMERS - 1);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } state_type;

   state_type                         state_ff, state_in;
   stb_pkg::mode_type                 mode_ff, mode_in;
   logic [IDX_W-1:0]                  idx_ff, idx_in;
   logic [stb_pkg::PERIOD_W-1:0]      period_ff, period_in;
   logic [stb_pkg::MASK_W-1:0]        fired_ff, fired_in;
   logic [NUM_TIMERS-1:0]             valid_ff, valid_in;
   logic                              rd_valid_ff, rd_valid_in;

   logic                              rd_en;
   logic [IDX_W-1:0]                  rd_addr;
   logic [stb_pkg::ENTRY_W-1:0]       rd_raw;
   logic                              wr_en;
   stb_pkg::entry_type                rd_entry;
   stb_pkg::entry_type                wr_entry;
   logic [stb_pkg::PERIOD_W-1:0]      dec_count;
   logic                              hit;
   logic                              check_flag;
   logic [stb_pkg::MASK_W-1:0]        fire_bits;
   logic [stb_pkg::ID_W-1:0]          idx_wide;
   logic                              last;

   stb_ram #(
      .WIDTH (stb_pkg::ENTRY_W),
      .DEPTH (NUM_TIMERS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (idx_ff),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   // Never-written entries read as zero
   assign rd_entry = rd_valid_ff ? stb_pkg::entry_type'(rd_raw) : '0;
   assign idx_wide = stb_pkg::ID_W'(idx_ff);
   assign last     = (mode_ff != stb_pkg::MODE_TICK) || (idx_ff == LAST_IDX);
   assign busy     = (state_ff != ST_IDLE);

   // Modify the entry that was just read
   always_comb begin
      wr_entry   = rd_entry;
      dec_count  = rd_entry.remaining - 16'd1;
      hit        = 1'b0;
      check_flag = 1'b0;
      unique case (mode_ff)
         stb_pkg::MODE_TICK: begin
            if (rd_entry.remaining != '0) begin
               wr_entry.remaining = dec_count;
               if (dec_count == '0) begin
                  hit                   = 1'b1;
                  wr_entry.expired_flag = 1'b1;
                  if (rd_entry.auto_reload) begin
                     wr_entry.remaining = rd_entry.reload_value;
                  end
               end
            end
         end
         stb_pkg::MODE_START_ONE,
         stb_pkg::MODE_START_AUTO: begin
            wr_entry.remaining    = period_ff;
            wr_entry.reload_value = period_ff;
            wr_entry.expired_flag = 1'b0;
            wr_entry.auto_reload  = (mode_ff == stb_pkg::MODE_START_AUTO);
         end
         stb_pkg::MODE_STOP: begin
            wr_entry.remaining    = '0;
            wr_entry.expired_flag = 1'b0;
            wr_entry.auto_reload  = 1'b0;
         end
         stb_pkg::MODE_CHECK: begin
            check_flag            = rd_entry.expired_flag;
            wr_entry.expired_flag = 1'b0;
         end
         default: begin
            wr_entry = rd_entry;
         end
      endcase
   end

   // Fired bit for the current entry; timers past the mask width get none
   always_comb begin
      for (int k = 0; k < stb_pkg::MASK_W; k++) begin
         fire_bits[k] = hit && (idx_wide == stb_pkg::ID_W'(k));
      end
   end

   // Sequence control: issue reads, write back, advance
   always_comb begin
      state_in    = state_ff;
      mode_in     = mode_ff;
      idx_in      = idx_ff;
      period_in   = period_ff;
      fired_in    = fired_ff;
      valid_in    = valid_ff;
      rd_en       = 1'b0;
      rd_addr     = '0;
      wr_en       = 1'b0;
      done        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (go) begin
               rd_en     = 1'b1;
               rd_addr   = (cmd.mode == stb_pkg::MODE_TICK) ? '0 : cmd.timer_id[IDX_W-1:0];
               mode_in   = cmd.mode;
               idx_in    = rd_addr;
               period_in = cmd.period;
               fired_in  = '0;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            wr_en            = 1'b1;
            valid_in[idx_ff] = 1'b1;
            fired_in         = fired_ff | fire_bits;
            if (last) begin
               done.valid      = 1'b1;
               done.expired    = check_flag;
               done.fired_mask = fired_ff | fire_bits;
               state_in        = ST_IDLE;
            end else begin
               rd_en   = 1'b1;
               rd_addr = idx_ff + 1'b1;
               idx_in  = rd_addr;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rd_valid_in = rd_en ? valid_ff[rd_addr] : rd_valid_ff;

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         valid_ff    <= valid_in;
         rd_valid_ff <= rd_valid_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      mode_ff   <= mode_in;
      idx_ff    <= idx_in;
      period_ff <= period_in;
      fired_ff  <= fired_in;
   end

endmodule

// ----- rtl/soft_timer_bank.sv -----
// ----------------------------------------------------------------------------
// soft_timer_bank
// Bank of NUM_TIMERS 16-bit down-counting software timers with one-shot and
// auto-reload modes, sticky expiry flags and run/free tick counters.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; exactly one result
// follows, shown for one cycle with rsp_valid high, and the receiver cannot
// hold it off. The timers live in a small memory that is read, modified and
// written back one entry per cycle. A tick sweeps every entry; start, stop
// and check touch one entry. Clear-free, unused modes and requests with a
// bad timer id are answered directly, without the sequencer. busy is high
// while the sequencer works on the memory after a tick, start, stop or
// check transfer; the other requests leave it low.
// Entries come out of reset as zero through per-entry valid bits, so no
// clearing pass is needed. A bad timer id is flagged and the access dropped.
// ----------------------------------------------------------------------------
module soft_timer_bank #(
   parameter int NUM_TIMERS = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [stb_pkg::MODE_W-1:0]         req_mode,
   input  logic [stb_pkg::ID_W-1:0]           req_timer_id,
   input  logic [stb_pkg::PERIOD_W-1:0]       req_period,
   output logic                               rsp_valid,
   output logic                               rsp_expired,
   output logic [stb_pkg::MASK_W-1:0]         rsp_fired_mask,
   output logic                               rsp_bad_id,
   output logic [stb_pkg::RUN_W-1:0]          rsp_run_time,
   output logic [stb_pkg::FREE_W-1:0]         rsp_free_run_time
);

   localparam logic [stb_pkg::ID_W-1:0] ID_LIMIT = stb_pkg::ID_W'(NUM_TIMERS);

   logic                          accept;
   stb_pkg::mode_type             mode;
   logic                          timer_op;
   logic                          bad_id;
   logic                          go;
   stb_pkg::cmd_type              cmd;
   stb_pkg::done_type             done;
   logic [stb_pkg::RUN_W-1:0]     run_inc;

   logic [stb_pkg::RUN_W-1:0]     tick_total_ff, tick_total_in;
   logic [stb_pkg::FREE_W-1:0]    free_ticks_ff, free_ticks_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_expired_ff, rsp_expired_in;
   logic [stb_pkg::MASK_W-1:0]    rsp_fired_ff, rsp_fired_in;
   logic                          rsp_bad_ff, rsp_bad_in;

   // Decode the request
   assign accept   = start && !busy;
   assign mode     = stb_pkg::mode_type'(req_mode);
   assign timer_op = (mode == stb_pkg::MODE_START_ONE) || (mode == stb_pkg::MODE_START_AUTO) ||
                     (mode == stb_pkg::MODE_STOP) || (mode == stb_pkg::MODE_CHECK);
   assign bad_id   = timer_op && (req_timer_id >= ID_LIMIT);
   assign go       = accept && ((mode == stb_pkg::MODE_TICK) || (timer_op && !bad_id));

   assign cmd.mode     = mode;
   assign cmd.timer_id = req_timer_id;
   assign cmd.period   = req_period;

   stb_seq #(
      .NUM_TIMERS (NUM_TIMERS)
   ) u_seq (
      .clock (clock),
      .reset (reset),
      .go    (go),
      .cmd   (cmd),
      .busy  (busy),
      .done  (done)
   );

   // Advance the tick counters on a tick transfer; clear-free zeroes the free counter
   assign run_inc = tick_total_ff + 1'b1;

   always_comb begin
      tick_total_in = tick_total_ff;
      free_ticks_in = free_ticks_ff;
      if (accept) begin
         if (mode == stb_pkg::MODE_TICK) begin
            tick_total_in = (run_inc == stb_pkg::RUN_WRAP) ? '0 : run_inc;
            free_ticks_in = free_ticks_ff + 1'b1;
         end else if (mode == stb_pkg::MODE_CLEAR_FREE) begin
            free_ticks_in = '0;
         end
      end
   end

   // Build the result: direct answer or sequencer completion
   always_comb begin
      rsp_valid_in   = 1'b0;
      rsp_expired_in = rsp_expired_ff;
      rsp_fired_in   = rsp_fired_ff;
      rsp_bad_in     = rsp_bad_ff;
      if (done.valid) begin
         rsp_valid_in   = 1'b1;
         rsp_expired_in = done.expired;
         rsp_fired_in   = done.fired_mask;
         rsp_bad_in     = 1'b0;
      end else if (accept && !go) begin
         rsp_valid_in   = 1'b1;
         rsp_expired_in = 1'b0;
         rsp_fired_in   = '0;
         rsp_bad_in     = bad_id;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_total_ff <= '0;
         free_ticks_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         tick_total_ff <= tick_total_in;
         free_ticks_ff <= free_ticks_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      rsp_expired_ff <= rsp_expired_in;
      rsp_fired_ff   <= rsp_fired_in;
      rsp_bad_ff     <= rsp_bad_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_expired       = rsp_expired_ff;
   assign rsp_fired_mask    = rsp_fired_ff;
   assign rsp_bad_id        = rsp_bad_ff;
   assign rsp_run_time      = tick_total_ff;
   assign rsp_free_run_time = free_ticks_ff;

endmodule

// ----- tb/soft_timer_bank_checker.sv -----
// ----------------------------------------------------------------------------
// soft_timer_bank_checker
// Watches the request and result channels of the timer bank. Keeps its own
// copy of every timer, the run counter and the free counter, works out the
// result of each accepted request and compares every result, field by
// field, with the oldest outstanding answer.
// ----------------------------------------------------------------------------
module soft_timer_bank_checker
   import stb_pkg::*;
#(
   parameter int NUM_TIMERS = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                busy,
   input  logic [MODE_W-1:0]   req_mode,
   input  logic [ID_W-1:0]     req_timer_id,
   input  logic [PERIOD_W-1:0] req_period,
   input  logic                rsp_valid,
   input  logic                rsp_expired,
   input  logic [MASK_W-1:0]   rsp_fired_mask,
   input  logic                rsp_bad_id,
   input  logic [RUN_W-1:0]    rsp_run_time,
   input  logic [FREE_W-1:0]   rsp_free_run_time,
   output int                  fail_count,
   output int                  pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic              expired;
      logic [MASK_W-1:0] fired_mask;
      logic              bad_id;
      logic [RUN_W-1:0]  run_time;
      logic [FREE_W-1:0] free_run_time;
   } timer_answer_type;

   // Shadow copy of the bank
   logic [PERIOD_W-1:0] count_left [NUM_TIMERS];
   logic [PERIOD_W-1:0] preload    [NUM_TIMERS];
   logic                flag_set   [NUM_TIMERS];
   logic                reloads    [NUM_TIMERS];
   logic [RUN_W-1:0]    run_ticks;
   logic [FREE_W-1:0]   free_ticks;

   timer_answer_type answer_q [$];
   int               mismatches  = 0;
   int               outstanding = 0;

   assign fail_count    = mismatches;
   assign pending_count = outstanding;

   // Apply one request to the shadow bank and return the answer it causes
   function automatic timer_answer_type apply_timer_request(
      input logic [MODE_W-1:0]   mode,
      input logic [ID_W-1:0]     id,
      input logic [PERIOD_W-1:0] period
   );
      timer_answer_type ans;
      int               t;
      ans = '0;
      t   = int'(id);
      case (mode)
         MODE_TICK: begin
            for (int i = 0; i < NUM_TIMERS; i++) begin
               if (count_left[i] != '0) begin
                  count_left[i] = count_left[i] - 1'b1;
                  if (count_left[i] == '0) begin
                     flag_set[i] = 1'b1;
                     if (reloads[i]) count_left[i] = preload[i];
                     if (i < MASK_W) ans.fired_mask[i] = 1'b1;
                  end
               end
            end
            run_ticks = run_ticks + 1'b1;
            if (run_ticks == RUN_WRAP) run_ticks = '0;
            free_ticks = free_ticks + 1'b1;
         end
         MODE_CLEAR_FREE: begin
            free_ticks = '0;
         end
         MODE_START_ONE, MODE_START_AUTO, MODE_STOP, MODE_CHECK: begin
            if (t >= NUM_TIMERS) begin
               ans.bad_id = 1'b1;
            end else if (mode == MODE_STOP) begin
               // stop keeps the preload
               count_left[t] = '0;
               flag_set[t]   = 1'b0;
               reloads[t]    = 1'b0;
            end else if (mode == MODE_CHECK) begin
               ans.expired = flag_set[t];
               flag_set[t] = 1'b0;
            end else begin
               count_left[t] = period;
               preload[t]    = period;
               flag_set[t]   = 1'b0;
               reloads[t]    = (mode == MODE_START_AUTO);
            end
         end
         default: begin
            // unused codes change nothing
         end
      endcase
      ans.run_time      = run_ticks;
      ans.free_run_time = free_ticks;
      return ans;
   endfunction

   // Compare results first, then log the request taken at the same edge
   always @(posedge clock) begin
      timer_answer_type want;
      if (reset) begin
         for (int i = 0; i < NUM_TIMERS; i++) begin
            count_left[i] = '0;
            preload[i]    = '0;
            flag_set[i]   = 1'b0;
            reloads[i]    = 1'b0;
         end
         run_ticks  = '0;
         free_ticks = '0;
         answer_q.delete();
      end else begin
         if (rsp_valid === 1'b1) begin
            if (answer_q.size() == 0) begin
               $error("result transfer with no request outstanding");
               mismatches++;
            end else begin
               want = answer_q.pop_front();
               if (rsp_expired !== want.expired) begin
                  $error("expired: expected %0d, got %0d", want.expired, rsp_expired);
                  mismatches++;
               end
               if (rsp_fired_mask !== want.fired_mask) begin
                  $error("fired_mask: expected 0x%02h, got 0x%02h",
                         want.fired_mask, rsp_fired_mask);
                  mismatches++;
               end
               if (rsp_bad_id !== want.bad_id) begin
                  $error("bad_id: expected %0d, got %0d", want.bad_id, rsp_bad_id);
                  mismatches++;
               end
               if (rsp_run_time !== want.run_time) begin
                  $error("run_time: expected %0d, got %0d", want.run_time, rsp_run_time);
                  mismatches++;
               end
               if (rsp_free_run_time !== want.free_run_time) begin
                  $error("free_run_time: expected %0d, got %0d",
                         want.free_run_time, rsp_free_run_time);
                  mismatches++;
               end
            end
         end
         if (start === 1'b1 && busy === 1'b0) begin
            answer_q.push_back(apply_timer_request(req_mode, req_timer_id, req_period));
         end
      end
      outstanding = answer_q.size();
   end

endmodule

// ----- tb/tb_soft_timer_bank.sv -----
// ----------------------------------------------------------------------------
// tb_soft_timer_bank
// Drives requests into the timer bank: a directed pass over starts, stops,
// checks, ticks, bad ids and unused codes, then random requests and short
// start/tick/check episodes under three sender idle profiles. The checker
// beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_soft_timer_bank;
   timeunit 1ns;
   timeprecision 1ps;

   import stb_pkg::*;

   localparam int NUM_TIMERS = 8;
   localparam int PHASE_ITEMS = 400;
   localparam int DRAIN_LIMIT = 1000;

   // Codes that the block does not define
   localparam logic [MODE_W-1:0] MODE_UNUSED_6 = 3'd6;
   localparam logic [MODE_W-1:0] MODE_UNUSED_7 = 3'd7;

   logic                clock        = 1'b0;
   logic                reset        = 1'b1;
   logic                start        = 1'b0;
   logic                busy;
   logic [MODE_W-1:0]   req_mode     = '0;
   logic [ID_W-1:0]     req_timer_id = '0;
   logic [PERIOD_W-1:0] req_period   = '0;
   logic                rsp_valid;
   logic                rsp_expired;
   logic [MASK_W-1:0]   rsp_fired_mask;
   logic                rsp_bad_id;
   logic [RUN_W-1:0]    rsp_run_time;
   logic [FREE_W-1:0]   rsp_free_run_time;
   int                  fail_count;
   int                  pending_count;

   int sender_idle_pct = 0;
   int useful_items    = 0;

   always #10 clock = ~clock;

   soft_timer_bank #(
      .NUM_TIMERS(NUM_TIMERS)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_mode         (req_mode),
      .req_timer_id     (req_timer_id),
      .req_period       (req_period),
      .rsp_valid        (rsp_valid),
      .rsp_expired      (rsp_expired),
      .rsp_fired_mask   (rsp_fired_mask),
      .rsp_bad_id       (rsp_bad_id),
      .rsp_run_time     (rsp_run_time),
      .rsp_free_run_time(rsp_free_run_time)
   );

   soft_timer_bank_checker #(
      .NUM_TIMERS(NUM_TIMERS)
   ) i_checker (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_mode         (req_mode),
      .req_timer_id     (req_timer_id),
      .req_period       (req_period),
      .rsp_valid        (rsp_valid),
      .rsp_expired      (rsp_expired),
      .rsp_fired_mask   (rsp_fired_mask),
      .rsp_bad_id       (rsp_bad_id),
      .rsp_run_time     (rsp_run_time),
      .rsp_free_run_time(rsp_free_run_time),
      .fail_count       (fail_count),
      .pending_count    (pending_count)
   );

   // Hold off at random, then present one request until the block takes it
   task automatic issue_request(
      input logic [MODE_W-1:0]   mode,
      input logic [ID_W-1:0]     id,
      input logic [PERIOD_W-1:0] period
   );
      logic ignored;
      ignored = (mode > MODE_CLEAR_FREE) ||
                (mode != MODE_TICK && mode != MODE_CLEAR_FREE && id >= NUM_TIMERS);
      while ($urandom_range(99) < sender_idle_pct) begin
         @(negedge clock);
         start        <= 1'b0;
         req_mode     <= MODE_W'($urandom);
         req_timer_id <= ID_W'($urandom);
         req_period   <= PERIOD_W'($urandom);
      end
      @(negedge clock);
      start        <= 1'b1;
      req_mode     <= mode;
      req_timer_id <= id;
      req_period   <= period;
      do @(posedge clock); while (busy !== 1'b0);
      if (!ignored) useful_items++;
   endtask

   // Mostly short periods so timers fire often; some idle and some full range
   function automatic logic [PERIOD_W-1:0] pick_period();
      int r;
      r = $urandom_range(99);
      if (r < 80) return PERIOD_W'($urandom_range(1, 12));
      if (r < 85) return '0;
      return PERIOD_W'($urandom);
   endfunction

   // One random request across all modes, with a little noise
   task automatic issue_random_request();
      int                r;
      logic [ID_W-1:0]   id;
      logic [MODE_W-1:0] mode;
      r  = $urandom_range(99);
      id = ID_W'($urandom_range(NUM_TIMERS - 1));
      if (r < 45)      mode = MODE_TICK;
      else if (r < 55) mode = MODE_START_ONE;
      else if (r < 65) mode = MODE_START_AUTO;
      else if (r < 72) mode = MODE_STOP;
      else if (r < 88) mode = MODE_CHECK;
      else if (r < 93) mode = MODE_CLEAR_FREE;
      else if (r < 96) mode = $urandom_range(1) ? MODE_UNUSED_7 : MODE_UNUSED_6;
      else begin
         // access with an out-of-range timer id
         mode = MODE_W'($urandom_range(MODE_START_ONE, MODE_CHECK));
         id   = ID_W'($urandom_range(NUM_TIMERS, 255));
      end
      if (mode == MODE_TICK || mode == MODE_CLEAR_FREE) id = ID_W'($urandom);
      issue_request(mode, id, pick_period());
   endtask

   // Arm one timer, tick it around its expiry, then read its flag
   task automatic run_timer_episode();
      logic [ID_W-1:0]     id;
      logic [PERIOD_W-1:0] len;
      id  = ID_W'($urandom_range(NUM_TIMERS - 1));
      len = PERIOD_W'($urandom_range(1, 6));
      issue_request($urandom_range(1) ? MODE_START_AUTO : MODE_START_ONE, id, len);
      repeat ($urandom_range(1, 2 * len + 1)) begin
         if ($urandom_range(9) == 0) begin
            issue_request(MODE_CHECK, id, PERIOD_W'($urandom));
         end else begin
            issue_request(MODE_TICK, ID_W'($urandom), PERIOD_W'($urandom));
         end
      end
      issue_request(MODE_CHECK, id, PERIOD_W'($urandom));
   endtask

   // Stimulus and verdict
   initial begin
      int drain;
      int target;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed pass, back to back
      sender_idle_pct = 0;
      issue_request(MODE_CHECK,      8'd0,   16'd0);
      issue_request(MODE_TICK,       8'd0,   16'd0);
      issue_request(MODE_START_ONE,  8'd0,   16'd1);
      issue_request(MODE_START_AUTO, 8'd1,   16'd2);
      issue_request(MODE_START_ONE,  8'd7,   16'hFFFF);
      issue_request(MODE_START_AUTO, 8'd2,   16'd0);
      issue_request(MODE_TICK,       8'd0,   16'd0);
      issue_request(MODE_TICK,       8'd0,   16'd0);
      issue_request(MODE_CHECK,      8'd0,   16'd0);
      issue_request(MODE_CHECK,      8'd0,   16'd0);
      issue_request(MODE_CHECK,      8'd1,   16'd0);
      issue_request(MODE_STOP,       8'd1,   16'd0);
      issue_request(MODE_TICK,       8'd0,   16'd0);
      issue_request(MODE_CHECK,      8'd8,   16'd0);
      issue_request(MODE_START_AUTO, 8'hFF,  16'hFFFF);
      issue_request(MODE_STOP,       8'h80,  16'd0);
      issue_request(MODE_UNUSED_6,   8'hFF,  16'hFFFF);
      issue_request(MODE_UNUSED_7,   8'hFF,  16'hFFFF);
      issue_request(MODE_CLEAR_FREE, 8'd0,   16'd0);
      issue_request(MODE_START_AUTO, 8'd3,   16'd1);
      issue_request(MODE_TICK,       8'd0,   16'd0);
      issue_request(MODE_TICK,       8'd0,   16'd0);
      issue_request(MODE_CHECK,      8'd3,   16'd0);
      issue_request(MODE_STOP,       8'd7,   16'd0);
      issue_request(MODE_CHECK,      8'd7,   16'd0);

      // random part: light, heavy, then no sender idling
      for (int p = 0; p < 3; p++) begin
         sender_idle_pct = (p == 0) ? 17 : (p == 1) ? 60 : 0;
         target          = useful_items + PHASE_ITEMS;
         while (useful_items < target) begin
            if ($urandom_range(99) < 35) run_timer_episode();
            else issue_random_request();
         end
      end
      @(negedge clock);
      start <= 1'b0;

      // drain outstanding results
      drain = 0;
      while (pending_count != 0 && drain < DRAIN_LIMIT) begin
         @(posedge clock);
         drain++;
      end
      if (pending_count != 0) begin
         $display("soft_timer_bank regression: fail");
      end else begin
         repeat (NUM_TIMERS + 8) @(posedge clock);
         @(negedge clock);
         if (fail_count == 0) begin
            $display("soft_timer_bank regression: pass");
         end else begin
            $display("soft_timer_bank regression: fail");
         end
      end
      $finish;
   end

   // Watchdog
   initial begin
      #5_000_000;
      $display("soft_timer_bank regression: fail");
      $finish;
   end

endmodule

// ----- soft_timer_bank.f -----
rtl/stb_pkg.sv
rtl/stb_ram.sv
rtl/stb_seq.sv
rtl/soft_timer_bank.sv
tb/soft_timer_bank_checker.sv
tb/tb_soft_timer_bank.sv
